>>> hw/rtl/alm_pkg.sv
// Shared types and constants of the audio level meter.
// Item and result records that move between the front, the queues and the back.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package alm_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int LEVEL_W     = 16;
	// squared magnitude of a 16-bit sample, at most 2^30
	localparam int SQ_W        = 31;
	// root radicand: 4 * acc / 2^frac, at most 2^32
	localparam int RAD_W       = SQ_W + 2;
	localparam int EIGHT_SHIFT = 8;

	// configuration register indexes
	localparam logic CFG_STEREO_MODE    = 1'b0;
	localparam logic CFG_EIGHT_BIT_MODE = 1'b1;

	// one classified sample item, front to back
	typedef struct packed {
		logic [SQ_W-1:0] sq_left;
		logic [SQ_W-1:0] sq_right;
		logic            last;
		logic            stereo;
		logic            eight;
	} item_t;

	// one meter result, back to output queue
	typedef struct packed {
		logic [LEVEL_W-1:0] level_left;
		logic [LEVEL_W-1:0] level_right;
		logic               posted;
	} result_t;

endpackage

`default_nettype wire

>>> hw/rtl/alm_queue.sv
// Small register FIFO used between front and back and for the results.
// Generic width and depth; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module alm_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/alm_front.sv
// Front end: configuration registers, sample squaring and item classification.
// Uses alm_pkg; feeds the item queue.
`timescale 1ns / 1ps
`default_nettype none

module alm_front
	import alm_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	// sample channel
	input  wire logic                push,
	output logic                     full,
	input  wire logic [SAMPLE_W-1:0] sample_left,
	input  wire logic [SAMPLE_W-1:0] sample_right,
	input  wire logic                last_in_buffer,
	// configuration channel
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic                cfg_index,
	input  wire logic                cfg_data,
	// item queue side
	output logic                     item_push,
	output item_t                    item,
	input  wire logic                item_full
);

	logic stereo_q;
	logic eight_q;

	// squared magnitude at the active sample width
	function automatic logic [SQ_W-1:0] square_of(input logic [SAMPLE_W-1:0] s,
	                                              input logic eight);
		logic signed [SAMPLE_W:0] v;
		logic        [SAMPLE_W:0] neg;
		logic        [SAMPLE_W-1:0] mag;
		if (eight) begin
			v = (SAMPLE_W + 1)'(signed'(s[7:0]));
		end else begin
			v = (SAMPLE_W + 1)'(signed'(s));
		end
		neg = -v;
		mag = v[SAMPLE_W] ? neg[SAMPLE_W-1:0] : v[SAMPLE_W-1:0];
		return SQ_W'(mag) * SQ_W'(mag);
	endfunction

	// configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stereo_q <= 1'b1;
			eight_q  <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_STEREO_MODE:    stereo_q <= cfg_data;
				CFG_EIGHT_BIT_MODE: eight_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// classify and hand over
	assign full      = item_full;
	assign item_push = push && !item_full;

	always_comb begin
		item.sq_left  = square_of(sample_left, eight_q);
		item.sq_right = square_of(sample_right, eight_q);
		item.last     = last_in_buffer;
		item.stereo   = stereo_q;
		item.eight    = eight_q;
	end

endmodule

`default_nettype wire

>>> hw/rtl/alm_sqrt.sv
// Iterative rounded square root: round(sqrt(acc / 2^FRAC_BITS)).
// One result bit per cycle with one 17x17 multiply; uses alm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module alm_sqrt
	import alm_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [SQ_W+FRAC_BITS-1:0]    operand,
	output logic                              done,
	output logic      [LEVEL_W-1:0]           root
);

	localparam int ACC_W = SQ_W + FRAC_BITS;
	localparam int IDX_W = $clog2(LEVEL_W);
	localparam int T_W   = LEVEL_W + 1;

	logic [RAD_W-1:0]   rad_q;
	logic [LEVEL_W-1:0] n_q;
	logic [IDX_W-1:0]   idx_q;
	logic               busy_q;
	logic               done_q;

	logic [ACC_W+1:0]   rad_full;
	logic [LEVEL_W-1:0] trial;
	logic [T_W-1:0]     t;
	logic [2*T_W-1:0]   t_sq;
	logic               fits;

	// radicand 4*acc/2^frac
	assign rad_full = {operand, 2'b00} >> FRAC_BITS;

	// largest n with (2n-1)^2 <= radicand, one bit a cycle
	always_comb begin
		trial = n_q | (LEVEL_W'(1) << idx_q);
		t     = {trial, 1'b0} - T_W'(1);
		t_sq  = t * t;
		fits  = (t_sq <= (2*T_W)'(rad_q));
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= rad_full[RAD_W-1:0];
			n_q   <= '0;
			idx_q <= IDX_W'(LEVEL_W - 1);
		end else if (busy_q) begin
			if (fits) begin
				n_q <= trial;
			end
			idx_q <= idx_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (idx_q == '0) && !start;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && idx_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign done = done_q;
	assign root = n_q;

endmodule

`default_nettype wire

>>> hw/rtl/alm_back.sv
// Back end: per-channel averaging, buffer-end roots and meter posting.
// Uses alm_pkg and alm_sqrt; reads the item queue, writes the result queue.
`timescale 1ns / 1ps
`default_nettype none

module alm_back
	import alm_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_empty,
	input  wire item_t item,
	output logic       item_pop,
	input  wire logic  res_full,
	output logic       res_push,
	output result_t    res
);

	localparam int ACC_W = SQ_W + FRAC_BITS;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_ROOT_L = 4'b0010,
		ST_ROOT_R = 4'b0100,
		ST_FIN    = 4'b1000
	} state_t;

	state_t             state_q;
	logic [ACC_W-1:0]   acc_l_q;
	logic [ACC_W-1:0]   acc_r_q;
	logic               first_q;
	logic               toggle_q;
	logic               stereo_q;
	logic [LEVEL_W-1:0] lvl_l_q;
	logic [LEVEL_W-1:0] lvl_r_q;

	logic [ACC_W-1:0]   acc_l_nxt;
	logic [ACC_W-1:0]   acc_r_nxt;
	logic [ACC_W-1:0]   base_l;
	logic [ACC_W-1:0]   base_r;
	logic [ACC_W-1:0]   term_l;
	logic [ACC_W-1:0]   term_r;
	logic [ACC_W:0]     sum_l;
	logic [ACC_W:0]     sum_r;
	logic [SQ_W-1:0]    scaled_l;
	logic [SQ_W-1:0]    scaled_r;
	logic [2*LEVEL_W-1:0] lvl_sq;
	logic               root_start;
	logic [ACC_W-1:0]   root_operand;
	logic               root_done;
	logic [LEVEL_W-1:0] root;

	assign item_pop = (state_q == ST_IDLE) && !item_empty;
	assign res_push = (state_q == ST_FIN) && !res_full;

	// averaging step, with seeding on the first sample after reset
	always_comb begin
		scaled_l = item.eight ? {item.sq_left[SQ_W-1-EIGHT_SHIFT:0], {EIGHT_SHIFT{1'b0}}}
		                      : item.sq_left;
		scaled_r = item.eight ? {item.sq_right[SQ_W-1-EIGHT_SHIFT:0], {EIGHT_SHIFT{1'b0}}}
		                      : item.sq_right;
		term_l   = ACC_W'(scaled_l) << FRAC_BITS;
		term_r   = ACC_W'(scaled_r) << FRAC_BITS;
		base_l   = first_q ? (ACC_W'(item.sq_left) << FRAC_BITS) : acc_l_q;
		base_r   = (first_q && item.stereo) ? (ACC_W'(item.sq_right) << FRAC_BITS) : acc_r_q;
		sum_l    = {1'b0, base_l} + {1'b0, term_l};
		sum_r    = {1'b0, base_r} + {1'b0, term_r};
		acc_l_nxt = sum_l[ACC_W:1];
		acc_r_nxt = item.stereo ? sum_r[ACC_W:1] : acc_r_q;
	end

	// root of left starts with the fresh accumulator, right after left finishes
	assign root_start   = (item_pop && item.last) ||
	                      ((state_q == ST_ROOT_L) && root_done && stereo_q);
	assign root_operand = (state_q == ST_IDLE) ? acc_l_nxt : acc_r_q;

	alm_sqrt #(
		.FRAC_BITS(FRAC_BITS)
	) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_start),
		.operand(root_operand),
		.done   (root_done),
		.root   (root)
	);

	// mono buffer end replaces the accumulators with the level squared
	assign lvl_sq = lvl_l_q * lvl_l_q;

	// sequencer and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			acc_l_q  <= '0;
			acc_r_q  <= '0;
			first_q  <= 1'b1;
			toggle_q <= 1'b0;
			stereo_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_pop) begin
						acc_l_q  <= acc_l_nxt;
						acc_r_q  <= acc_r_nxt;
						first_q  <= 1'b0;
						stereo_q <= item.stereo;
						if (item.last) begin
							state_q <= ST_ROOT_L;
						end
					end
				end
				ST_ROOT_L: begin
					if (root_done) begin
						state_q <= stereo_q ? ST_ROOT_R : ST_FIN;
					end
				end
				ST_ROOT_R: begin
					if (root_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (res_push) begin
						state_q <= ST_IDLE;
						if (!stereo_q) begin
							acc_l_q <= ACC_W'(lvl_sq) << FRAC_BITS;
							acc_r_q <= ACC_W'(lvl_sq) << FRAC_BITS;
						end
						if (!toggle_q) begin
							toggle_q <= 1'b1;
						end else if (stereo_q) begin
							toggle_q <= 1'b0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// captured levels
	always_ff @(posedge clk) begin
		if (state_q == ST_ROOT_L && root_done) begin
			lvl_l_q <= root;
			if (!stereo_q) begin
				lvl_r_q <= root;
			end
		end
		if (state_q == ST_ROOT_R && root_done) begin
			lvl_r_q <= root;
		end
	end

	always_comb begin
		res.level_left  = lvl_l_q;
		res.level_right = lvl_r_q;
		res.posted      = toggle_q;
	end

endmodule

`default_nettype wire

>>> hw/rtl/audio_level_meter_core.sv
// Audio level meter: exponential average of squared samples per channel,
// rounded root levels reported at each buffer end.
// Channels: a sample queue (push/full) and a result queue (empty/pop), both
// queue-style; a config write port (cfg_valid/cfg_ready, cfg_index, cfg_data)
// that is always ready: index 0 stereo_mode, index 1 eight_bit_mode.
// An item that is not marked last in buffer causes no result and leaves the
// back end idle, so such items stream at one per cycle while no buffer end
// is in progress. A last item runs the bit-serial root unit, one channel in
// mono and two in stereo, the right root starting once the left is taken;
// the rounded levels are then posted. The back end takes no new item from
// the last item until its result is in the result queue.
// Two-entry queues sit before and after the back end, so the front keeps
// taking samples, until the item queue is full, while a root runs or a
// result waits. If the receiver stops popping, the result queue fills, the
// back end holds its result and the sample queue fills, raising full.
// Reset (arst_n low, asynchronous) clears both queues, zeroes the averages,
// arms seeding of the first sample and sets stereo mode, 16-bit samples.
`timescale 1ns / 1ps
`default_nettype none

module audio_level_meter_core
	import alm_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// sample queue
	input  wire logic                push,
	output logic                     full,
	input  wire logic [SAMPLE_W-1:0] sample_left,
	input  wire logic [SAMPLE_W-1:0] sample_right,
	input  wire logic                last_in_buffer,
	// result queue
	output logic                     empty,
	input  wire logic                pop,
	output logic      [LEVEL_W-1:0]  level_left,
	output logic      [LEVEL_W-1:0]  level_right,
	output logic                     meters_updated,
	// configuration
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic                cfg_index,
	input  wire logic                cfg_data
);

	logic    item_push;
	logic    item_full;
	logic    item_pop;
	logic    item_empty;
	item_t   item_in;
	item_t   item_out;
	logic    res_push;
	logic    res_full;
	result_t res_in;
	result_t res_out;

	// front end
	alm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.sample_left   (sample_left),
		.sample_right  (sample_right),
		.last_in_buffer(last_in_buffer),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.item_push     (item_push),
		.item          (item_in),
		.item_full     (item_full)
	);

	// item queue between front and back
	alm_queue #(
		.WIDTH($bits(item_t)),
		.DEPTH(2)
	) u_item_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (item_push),
		.wdata (item_in),
		.full  (item_full),
		.pop   (item_pop),
		.rdata (item_out),
		.empty (item_empty)
	);

	// back end
	alm_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_empty(item_empty),
		.item      (item_out),
		.item_pop  (item_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	// result queue
	alm_queue #(
		.WIDTH($bits(result_t)),
		.DEPTH(2)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_out),
		.empty (empty)
	);

	assign level_left     = res_out.level_left;
	assign level_right    = res_out.level_right;
	assign meters_updated = res_out.posted;

`ifndef SYNTHESIS
	// back end never pushes into a full result queue
	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into full queue");

	// back end only pops a waiting item
	a_item_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		item_pop |-> !item_empty)
		else $error("item popped from empty queue");

	// a result push is followed by the result queue holding an entry
	a_res_lands: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> !empty)
		else $error("pushed result not visible");
`endif

endmodule

`default_nettype wire

>>> bench/audio_level_meter_core_tb.sv
// Self-checking bench for audio_level_meter_core: directed rows, then random phases.
// A local predictor computes levels and the posted flag for each buffer end.
// Depends on alm_pkg and the RTL top audio_level_meter_core.
`timescale 1ns / 1ps

module audio_level_meter_core_tb;
	import alm_pkg::*;

	localparam int FRAC          = 16;
	localparam int N_DIRECTED    = 18;
	localparam int RAND_ITEMS    = 1632;
	// back end work still in flight once the last level has come out
	localparam int SETTLE_CYCLES = 64;
	localparam int IDLE_LIMIT    = 2000;

	// one stimulus row; want is used only where typed is set
	typedef struct packed {
		logic                stereo;
		logic                eight;
		logic [SAMPLE_W-1:0] left;
		logic [SAMPLE_W-1:0] right;
		logic                last;
		logic                typed;
		result_t             want;
	} step_row_t;

	localparam result_t NO_LVL = '0;

	// mono seed and steady full scale first, then stereo, eight-bit, mode changes mid-buffer
	localparam step_row_t DIRECTED [N_DIRECTED] = '{
		'{1'b0, 1'b0, 16'h8000, 16'h1234, 1'b1, 1'b1, '{16'd32768, 16'd32768, 1'b0}},
		'{1'b0, 1'b0, 16'h8000, 16'h0000, 1'b1, 1'b1, '{16'd32768, 16'd32768, 1'b1}},
		'{1'b1, 1'b0, 16'h7FFF, 16'h8000, 1'b0, 1'b0, NO_LVL},
		'{1'b1, 1'b0, 16'h0000, 16'h8000, 1'b1, 1'b0, NO_LVL},
		'{1'b1, 1'b0, 16'h8000, 16'h8000, 1'b1, 1'b0, NO_LVL},
		'{1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, NO_LVL},
		'{1'b1, 1'b0, 16'h0001, 16'hFFFF, 1'b1, 1'b0, NO_LVL},
		'{1'b1, 1'b1, 16'h3F80, 16'hC07F, 1'b0, 1'b0, NO_LVL},
		'{1'b1, 1'b1, 16'hFF80, 16'h0080, 1'b1, 1'b0, NO_LVL},
		'{1'b1, 1'b1, 16'hFFFF, 16'h7F00, 1'b1, 1'b0, NO_LVL},
		'{1'b0, 1'b1, 16'h1280, 16'hFFFF, 1'b1, 1'b0, NO_LVL},
		'{1'b0, 1'b1, 16'hAB7F, 16'h0000, 1'b0, 1'b0, NO_LVL},
		'{1'b0, 1'b1, 16'h00FF, 16'h5555, 1'b1, 1'b0, NO_LVL},
		'{1'b0, 1'b0, 16'h7FFF, 16'hAAAA, 1'b1, 1'b0, NO_LVL},
		'{1'b0, 1'b0, 16'h0000, 16'h0000, 1'b1, 1'b0, NO_LVL},
		'{1'b0, 1'b0, 16'h8001, 16'h7FFF, 1'b0, 1'b0, NO_LVL},
		'{1'b1, 1'b0, 16'h8000, 16'h7FFF, 1'b1, 1'b0, NO_LVL},
		'{1'b1, 1'b0, 16'hFFFF, 16'h0001, 1'b1, 1'b0, NO_LVL}
	};

	logic                clk;
	logic                arst_n;
	logic                push;
	logic                full;
	logic [SAMPLE_W-1:0] sample_left;
	logic [SAMPLE_W-1:0] sample_right;
	logic                last_in_buffer;
	logic                empty;
	logic                pop;
	logic [LEVEL_W-1:0]  level_left;
	logic [LEVEL_W-1:0]  level_right;
	logic                meters_updated;
	logic                cfg_valid;
	logic                cfg_ready;
	logic                cfg_index;
	logic                cfg_data;

	audio_level_meter_core #(
		.FRAC_BITS(FRAC)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.sample_left   (sample_left),
		.sample_right  (sample_right),
		.last_in_buffer(last_in_buffer),
		.empty         (empty),
		.pop           (pop),
		.level_left    (level_left),
		.level_right   (level_right),
		.meters_updated(meters_updated),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// predictor state
	logic [63:0] avg_left;
	logic [63:0] avg_right;
	logic        stereo_on;
	logic        eight_on;
	logic        seed_pending;
	logic        post_armed;

	result_t pending_levels [$];
	int      errors;
	int      n_items;
	int      n_results;
	int      n_posted;
	int      n_cfg_writes;

	// squared magnitude at the active sample width
	function automatic logic [63:0] square_mag(input logic [SAMPLE_W-1:0] f);
		logic [15:0] v;
		logic [15:0] mag;
		v   = eight_on ? {{8{f[7]}}, f[7:0]} : f;
		mag = v[15] ? (~v + 16'd1) : v;
		return 64'(mag) * 64'(mag);
	endfunction

	// acc = (acc + term) / 2, truncating
	function automatic logic [63:0] blend(input logic [63:0] acc, input logic [63:0] sq);
		logic [63:0] term;
		term = eight_on ? (sq << EIGHT_SHIFT) : sq;
		term = term << FRAC;
		return (acc + term) >> 1;
	endfunction

	// nearest integer root: largest n with (2n-1)^2 <= 4 * acc / 2^FRAC
	function automatic logic [63:0] root_level(input logic [63:0] acc);
		logic [63:0] w;
		logic [63:0] n;
		logic [63:0] c;
		logic [63:0] t;
		w = acc >> (FRAC - 2);
		n = '0;
		for (int b = 16; b >= 0; b--) begin
			c = n | (64'd1 << b);
			t = 2 * c - 1;
			if (t * t <= w)
				n = c;
		end
		return n;
	endfunction

	// advance the predictor by one item; returns 1 when a result is due
	function automatic bit meter_step(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r,
			input logic last, output result_t res);
		logic [63:0] sql;
		logic [63:0] sqr;
		logic [63:0] lvl;
		logic [63:0] lvr;
		sql = square_mag(l);
		sqr = square_mag(r);
		res = '0;
		// first item after reset seeds with the unshifted square
		if (seed_pending) begin
			avg_left = sql << FRAC;
			if (stereo_on)
				avg_right = sqr << FRAC;
			seed_pending = 1'b0;
		end
		avg_left = blend(avg_left, sql);
		if (stereo_on)
			avg_right = blend(avg_right, sqr);
		if (!last)
			return 1'b0;
		lvl = root_level(avg_left);
		if (stereo_on) begin
			lvr = root_level(avg_right);
		end else begin
			lvr       = lvl;
			avg_left  = (lvl * lvl) << FRAC;
			avg_right = avg_left;
		end
		res.posted = post_armed;
		if (!post_armed)
			post_armed = 1'b1;
		else if (stereo_on)
			post_armed = 1'b0;
		res.level_left  = lvl[LEVEL_W-1:0];
		res.level_right = lvr[LEVEL_W-1:0];
		return 1'b1;
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		logic [SAMPLE_W-1:0] s;
		case ($urandom_range(0, 7))
			0: s = 16'h8000;
			1: s = 16'h7FFF;
			2: s = 16'h0000;
			3: s = $urandom_range(0, 1) ? 16'hFFFF : 16'h0001;
			4: s = $urandom_range(0, 1) ? 16'($urandom_range(0, 255)) : -16'($urandom_range(0, 255));
			default: s = 16'($urandom);
		endcase
		return s;
	endfunction

	// hold push low for the gap argument, then present one item and wait until it is taken
	task automatic send_item(input step_row_t row, input int gap);
		result_t res;
		if (gap != 0) begin
			@(negedge clk) push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push           <= 1'b1;
		sample_left    <= row.left;
		sample_right   <= row.right;
		last_in_buffer <= row.last;
		do @(posedge clk); while (full);
		n_items++;
		if (meter_step(row.left, row.right, row.last, res)) begin
			if (row.typed)
				res = row.want;
			pending_levels = {pending_levels, res};
		end
	endtask

	task automatic write_reg(input logic idx, input logic val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_STEREO_MODE)
			stereo_on = val;
		else
			eight_on = val;
		n_cfg_writes++;
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	// hold off, let the block go idle, then load a new register setting
	task automatic change_mode(input logic st, input logic eb);
		@(negedge clk) push <= 1'b0;
		while (pending_levels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(CFG_STEREO_MODE, st);
		write_reg(CFG_EIGHT_BIT_MODE, eb);
	endtask

	// stimulus
	initial begin : stimulus
		step_row_t row;
		int        rand_sent;
		int        phase;
		int        plen;
		int        buf_left;
		bit        calm;
		logic      st;
		logic      eb;
		arst_n         <= 1'b0;
		push           <= 1'b0;
		sample_left    <= '0;
		sample_right   <= '0;
		last_in_buffer <= 1'b0;
		cfg_valid      <= 1'b0;
		cfg_index      <= CFG_STEREO_MODE;
		cfg_data       <= 1'b0;
		avg_left     = '0;
		avg_right    = '0;
		stereo_on    = 1'b1;
		eight_on     = 1'b0;
		seed_pending = 1'b1;
		post_armed   = 1'b0;
		errors       = 0;
		n_items      = 0;
		n_results    = 0;
		n_posted     = 0;
		n_cfg_writes = 0;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed rows; a mode change drains the block first
		change_mode(DIRECTED[0].stereo, DIRECTED[0].eight);
		for (int i = 0; i < N_DIRECTED; i++) begin
			if (DIRECTED[i].stereo != stereo_on || DIRECTED[i].eight != eight_on)
				change_mode(DIRECTED[i].stereo, DIRECTED[i].eight);
			send_item(DIRECTED[i], $urandom_range(0, 19));
		end

		// random phases, each with its own setting; buffers may span phases
		rand_sent = 0;
		phase     = 0;
		buf_left  = 1;
		while (rand_sent < RAND_ITEMS) begin
			if (phase < 4) begin
				st = phase[0];
				eb = phase[1];
			end else begin
				st = $urandom_range(0, 1);
				eb = $urandom_range(0, 1);
			end
			change_mode(st, eb);
			calm = ($urandom_range(0, 3) == 0);
			plen = $urandom_range(60, 200);
			for (int k = 0; k < plen && rand_sent < RAND_ITEMS; k++) begin
				if (buf_left == 0) begin
					case ($urandom_range(0, 19))
						0:       buf_left = $urandom_range(41, 120);
						1, 2, 3: buf_left = $urandom_range(13, 40);
						default: buf_left = $urandom_range(1, 12);
					endcase
				end
				row        = '0;
				row.stereo = st;
				row.eight  = eb;
				row.left   = pick_sample();
				row.right  = pick_sample();
				row.last   = (buf_left == 1);
				buf_left--;
				send_item(row, calm ? 0 : $urandom_range(0, 19));
				rand_sent++;
			end
			phase++;
		end

		@(negedge clk) push <= 1'b0;
		while (pending_levels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d sample items, %0d meter results (%0d posted), %0d register writes.",
			n_items, n_results, n_posted, n_cfg_writes);
		$display("Settings spanned mono/stereo and 8/16-bit samples, %0d random phases.", phase);
		if (errors == 0 && pending_levels.size() == 0) begin
			$display("audio_level_meter_core regression: pass");
		end else begin
			$display("audio_level_meter_core regression: fail");
		end
		$finish;
	end

	// result side: random pop stalls, compare against the oldest expectation
	initial begin : result_drain
		int      gap;
		bit      calm;
		result_t want;
		pop <= 1'b0;
		calm = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = calm ? 0 : $urandom_range(0, 19);
			if (gap != 0) begin
				@(negedge clk) pop <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk) pop <= 1'b1;
			do @(posedge clk); while (empty);
			n_results++;
			if (meters_updated)
				n_posted++;
			if (pending_levels.size() == 0) begin
				$error("meter result with nothing expected: left %0d right %0d updated %0d",
					level_left, level_right, meters_updated);
				errors++;
			end else begin
				want = pending_levels.pop_front();
				if (level_left !== want.level_left) begin
					$error("level_left: expected %0d, actual %0d", want.level_left, level_left);
					errors++;
				end
				if (level_right !== want.level_right) begin
					$error("level_right: expected %0d, actual %0d", want.level_right, level_right);
					errors++;
				end
				if (meters_updated !== want.posted) begin
					$error("meters_updated: expected %0d, actual %0d", want.posted, meters_updated);
					errors++;
				end
			end
			if ($urandom_range(0, 29) == 0)
				calm = !calm;
		end
	end

	// watchdog: too long without any handshake ends the run
	int idle_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("audio_level_meter_core regression: fail");
				$finish;
			end
		end
	end

endmodule
